@@ sv/gncl_pkg.sv @@
// ----------------------------------------------------------------------------
// gncl_pkg: shared types and constants of the grid neighbour cell lister
// Command and status codes, heading tables and the slot list builder.
// ----------------------------------------------------------------------------
package gncl_pkg;

	// Field widths fixed by the interface.
	localparam int PW       = 14;
	localparam int HW       = 3;
	localparam int NSLOT    = 8;
	localparam int CW       = 4;
	localparam int DIM_W    = 8;
	localparam int MAX_GRID_DEF = 128;
	localparam logic [DIM_W-1:0] DIM_RESET = 8'd69;

	// Command codes.
	localparam logic [1:0] CMD_ALL    = 2'd0;
	localparam logic [1:0] CMD_AHEAD  = 2'd1;
	localparam logic [1:0] CMD_BEHIND = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_EMPTY       = 2'd1,
		ST_BAD_HEADING = 2'd2,
		ST_OUTSIDE     = 2'd3
	} status_t;

	// Register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [HW-1:0] head_t;

	// Headings that step in each direction, one bit per heading.
	localparam logic [NSLOT-1:0] EAST_MASK  = 8'b0000_1110;
	localparam logic [NSLOT-1:0] WEST_MASK  = 8'b1110_0000;
	localparam logic [NSLOT-1:0] NORTH_MASK = 8'b1000_0011;
	localparam logic [NSLOT-1:0] SOUTH_MASK = 8'b0011_1000;

	// Heading lists for the cells ahead and behind, visited in this order.
	localparam head_t AHEAD_LIST [0:7][0:4] = '{
		'{3'd7, 3'd0, 3'd1, 3'd0, 3'd0}, '{3'd7, 3'd0, 3'd1, 3'd2, 3'd3},
		'{3'd3, 3'd2, 3'd1, 3'd0, 3'd0}, '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1},
		'{3'd5, 3'd4, 3'd3, 3'd0, 3'd0}, '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3},
		'{3'd7, 3'd6, 3'd5, 3'd0, 3'd0}, '{3'd5, 3'd6, 3'd7, 3'd0, 3'd1}
	};
	localparam head_t BEHIND_LIST [0:7][0:4] = '{
		'{3'd5, 3'd4, 3'd3, 3'd0, 3'd0}, '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3},
		'{3'd7, 3'd6, 3'd5, 3'd0, 3'd0}, '{3'd5, 3'd6, 3'd7, 3'd0, 3'd1},
		'{3'd7, 3'd0, 3'd1, 3'd0, 3'd0}, '{3'd3, 3'd2, 3'd1, 3'd0, 3'd7},
		'{3'd3, 3'd2, 3'd1, 3'd0, 3'd0}, '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1}
	};
	localparam logic [CW-1:0] LIST_LEN [0:7] = '{
		4'd3, 4'd5, 4'd3, 4'd5, 4'd3, 4'd5, 4'd3, 4'd5
	};

	// Ordered heading slots of one request and how many of them are used.
	typedef struct packed {
		logic [NSLOT-1:0][HW-1:0] head;
		logic [CW-1:0]            count;
	} slots_t;

	// The part of a word that travels down the pipeline; only its status can change on the way.
	typedef struct packed {
		logic [PW-1:0] pos;
		status_t       err;
		slots_t        sl;
	} item_t;

	// Builds the slot list for a command and heading.
	function automatic slots_t list_slots(input logic [1:0] cmd, input head_t dir);
		slots_t r;
		r.count = 4'(NSLOT);
		for (int i = 0; i < NSLOT; i++) begin
			r.head[i] = 3'(i);
		end
		case (cmd)
			CMD_AHEAD: begin
				r.count = LIST_LEN[dir];
				for (int i = 0; i < 5; i++) begin
					r.head[i] = AHEAD_LIST[dir][i];
				end
			end
			CMD_BEHIND: begin
				r.count = LIST_LEN[dir];
				for (int i = 0; i < 5; i++) begin
					r.head[i] = BEHIND_LIST[dir][i];
				end
			end
			default: begin
				r.count = 4'(NSLOT);
			end
		endcase
		return r;
	endfunction

endpackage

@@ sv/grid_neighbor_cell_lister.sv @@
// ----------------------------------------------------------------------------
// grid_neighbor_cell_lister: lists the in-grid neighbours of one cell
// Pipelined index split, bounds test and serial emission of neighbour words.
// ----------------------------------------------------------------------------
// Usage
// A request word (command, position, direction) is taken on the req channel
// when req_valid and req_ready are both high. Each request gives a run of one
// to eight result words on the rsp channel, the final one marked by last;
// an error or an empty list gives a single word carrying the status code.
// Grid width and height are set through the APB port at addresses 0 and 4;
// the user must write them only while the block is idle, which the block
// itself does not enforce. pready is always high. A request passes the
// decode register, loaded at the accepting edge, fourteen restoring divider
// stages that split the index into row and column, one bounds stage and
// the output register. Throughput: the pipeline takes a word in every
// cycle unless a stall holds it; the output register sends one result per
// cycle while rsp_ready is high, holding a request until all its results
// (1 to 8) are sent, and that register sets the sustained rate.
// Reset clears all valid bits and sets both grid sizes to 69.
// When the receiver stalls, the result holds and the stages fill up one by
// one, bubbles closing, until req_ready falls; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module grid_neighbor_cell_lister
	import gncl_pkg::*;
#(
	parameter int MAX_GRID = MAX_GRID_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Request channel
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           command,
	input  logic [PW-1:0]        position,
	input  logic [3:0]           direction,
	// Result channel
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [PW-1:0]        neighbor_index,
	output logic [1:0]           status,
	output logic                 last,
	// Configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int DW   = $clog2(MAX_GRID + 1);
	localparam int YW   = PW + 1;
	localparam int NDIV = PW;

	// Clamps a grid size to the supported range.
	function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v < DIM_W'(2)) begin
			return DW'(2);
		end else if (32'(v) > MAX_GRID) begin
			return DW'(MAX_GRID);
		end
		return DW'(v);
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0] width_q, height_q;
	logic [DW-1:0]    gw, gh;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_WIDTH) begin
				width_q <= pwdata[DIM_W-1:0];
			end else begin
				height_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_WIDTH) ? 32'(width_q) : 32'(height_q);
	assign gw = clamp_dim(width_q);
	assign gh = clamp_dim(height_q);

	// Stage enables: a stage moves when it is empty or its successor moves.
	logic            en_s1, en_s3, en_em;
	logic [NDIV-1:0] en_s2;

	// Stage 1: register the request, check the heading, build slots.
	logic  v_s1;
	item_t it_s1;
	status_t err_in;

	always_comb begin
		if (command == CMD_UNUSED || (command != CMD_ALL && direction[3])) begin
			err_in = ST_BAD_HEADING;
		end else begin
			err_in = ST_OK;
		end
	end

	assign req_ready = en_s1;
	assign en_s1 = !v_s1 || en_s2[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			it_s1.pos <= position;
			it_s1.err <= err_in;
			it_s1.sl  <= list_slots(command, direction[HW-1:0]);
		end
	end

	// Stage 2: restoring divider, one quotient bit per stage, giving row
	// (quotient) and column (remainder) of the index.
	logic            v_s2   [NDIV];
	item_t           it_s2  [NDIV];
	logic [DW-1:0]   rem_s2 [NDIV];
	logic [PW-1:0]   quo_s2 [NDIV];

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic          v_in;
		item_t         it_in;
		logic [DW-1:0] rem_in;
		logic [PW-1:0] quo_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in   = v_s1;
			assign it_in  = it_s1;
			assign rem_in = '0;
			assign quo_in = '0;
		end else begin : g_next
			assign v_in   = v_s2[k-1];
			assign it_in  = it_s2[k-1];
			assign rem_in = rem_s2[k-1];
			assign quo_in = quo_s2[k-1];
		end

		if (k == NDIV - 1) begin : g_en_last
			assign en_s2[k] = !v_s2[k] || en_s3;
		end else begin : g_en_mid
			assign en_s2[k] = !v_s2[k] || en_s2[k+1];
		end

		assign trial = {rem_in, it_in.pos[PW-1-k]};
		assign ge    = trial >= {1'b0, gw};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (en_s2[k]) begin
				v_s2[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s2[k]) begin
				it_s2[k]  <= it_in;
				rem_s2[k] <= ge ? DW'(trial - {1'b0, gw}) : DW'(trial);
				quo_s2[k] <= {quo_in[PW-2:0], ge};
			end
		end
	end

	// Stage 3: position check, bounds test and index of the neighbour in
	// each heading.
	logic                     v_s3;
	item_t                    it_s3;
	item_t                    it_nx;
	logic [NSLOT-1:0]         ok_s3;
	logic [NSLOT-1:0][PW-1:0] idx_s3;
	logic [NSLOT-1:0]         ok_nx;
	logic [NSLOT-1:0][PW-1:0] idx_nx;
	logic [DW-1:0]            col;
	logic [PW-1:0]            row, base, wp;
	logic                     at_east, at_west, at_north, at_south;
	logic                     outside;

	assign col      = rem_s2[NDIV-1];
	assign row      = quo_s2[NDIV-1];
	assign base     = it_s2[NDIV-1].pos;
	assign wp       = PW'(gw);
	assign at_east  = col == gw - DW'(1);
	assign at_west  = col == '0;
	assign at_north = row == '0;
	assign at_south = YW'(row) + YW'(1) >= YW'(gh);
	assign outside  = YW'(row) >= YW'(gh);

	// An index whose row lies past the last row is outside the grid; a bad
	// heading found earlier takes precedence.
	always_comb begin
		it_nx = it_s2[NDIV-1];
		if (it_nx.err == ST_OK && outside) begin
			it_nx.err = ST_OUTSIDE;
		end
	end

	always_comb begin
		for (int h = 0; h < NSLOT; h++) begin
			ok_nx[h] = !(EAST_MASK[h] && at_east) && !(WEST_MASK[h] && at_west) &&
			           !(NORTH_MASK[h] && at_north) && !(SOUTH_MASK[h] && at_south);
			idx_nx[h] = base + (EAST_MASK[h] ? PW'(1) : '0) - (WEST_MASK[h] ? PW'(1) : '0)
			          + (SOUTH_MASK[h] ? wp : '0) - (NORTH_MASK[h] ? wp : '0);
		end
	end

	assign en_s3 = !v_s3 || en_em;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2[NDIV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			it_s3  <= it_nx;
			ok_s3  <= ok_nx;
			idx_s3 <= idx_nx;
		end
	end

	// Output register: put the headings in slot order, then send the
	// marked slots one word per cycle while rsp_ready is high, lowest slot first.
	logic                     em_valid_q;
	logic [NSLOT-1:0]         em_mask_q;
	logic [NSLOT-1:0][PW-1:0] em_idx_q;
	status_t                  em_st_q;
	logic [NSLOT-1:0]         slot_ok, ld_mask, rest_mask;
	logic [NSLOT-1:0][PW-1:0] ld_idx;
	status_t                  ld_st;
	logic [HW-1:0]            sel;
	logic                     one_left;

	always_comb begin
		for (int j = 0; j < NSLOT; j++) begin
			slot_ok[j] = ok_s3[it_s3.sl.head[j]] && (CW'(j) < it_s3.sl.count);
		end
		if (it_s3.err != ST_OK) begin
			ld_st = it_s3.err;
		end else if (slot_ok == '0) begin
			ld_st = ST_EMPTY;
		end else begin
			ld_st = ST_OK;
		end
		ld_mask = (ld_st == ST_OK) ? slot_ok : NSLOT'(1);
		for (int j = 0; j < NSLOT; j++) begin
			ld_idx[j] = (ld_st == ST_OK) ? idx_s3[it_s3.sl.head[j]] : '0;
		end
	end

	// Lowest marked slot.
	always_comb begin
		sel = '0;
		for (int j = NSLOT - 1; j >= 0; j--) begin
			if (em_mask_q[j]) begin
				sel = 3'(j);
			end
		end
	end

	assign rest_mask = em_mask_q & (em_mask_q - NSLOT'(1));
	assign one_left  = rest_mask == '0;
	assign en_em     = !em_valid_q || (rsp_ready && one_left);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
		end else if (en_em) begin
			em_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_em) begin
			em_mask_q <= ld_mask;
			em_idx_q  <= ld_idx;
			em_st_q   <= ld_st;
		end else if (rsp_ready) begin
			em_mask_q <= rest_mask;
		end
	end

	assign rsp_valid      = em_valid_q;
	assign neighbor_index = em_idx_q[sel];
	assign status         = em_st_q;
	assign last           = one_left;

	// An error or empty result is a single word with a zero index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> (last && neighbor_index == '0))
	else $error("error result is not a lone zero word");

	// A held result word always has at least one slot left to send.
	assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q |-> ($countones(em_mask_q) > 0))
	else $error("result register valid with no slot left");

	// A word stalled at the output keeps its index and status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(neighbor_index) && $stable(status)))
	else $error("stalled result changed");

	// A word in the decode stage that cannot move blocks the request side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en_s2[0]) |-> !req_ready)
	else $error("request taken while decode stage is blocked");

endmodule
